// ===== hdl/rsag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsag_pkg;

  // Fixed-point format of the sine / cosine values
  localparam int FRAC_BITS = 16;
  localparam int TRIG_W    = FRAC_BITS + 2;   // signed, holds +/- 1.0
  localparam int ROM_W     = FRAC_BITS + 1;   // unsigned magnitude, holds 1.0

  // Image size limit and field widths
  localparam int MAX_DIM   = 2048;
  localparam int COORD_W   = 11;
  localparam int DIM_W     = 12;
  localparam int ANGLE_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Reset values
  localparam logic [DIM_W-1:0] DIM_RESET = 12'd1024;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_dest_x;
    logic [COORD_W-1:0] out_dest_y;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               in_range;
  } out_t;

  // Settings handed from the register block to the datapath
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic [DIM_W-1:0]         width;   // saturated to MAX_DIM
    logic [DIM_W-1:0]         height;  // saturated to MAX_DIM
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  // sin(d degrees) * 2^16, rounded, d = 0..90
  function automatic logic [ROM_W-1:0] sin_rom(input logic [6:0] d);
    logic [ROM_W-1:0] v;
    case (d)
      7'd0:  v = 17'd0;
      7'd1:  v = 17'd1144;
      7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;
      7'd4:  v = 17'd4572;
      7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;
      7'd7:  v = 17'd7987;
      7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252;
      7'd10: v = 17'd11380;
      7'd11: v = 17'd12505;
      7'd12: v = 17'd13626;
      7'd13: v = 17'd14742;
      7'd14: v = 17'd15855;
      7'd15: v = 17'd16962;
      7'd16: v = 17'd18064;
      7'd17: v = 17'd19161;
      7'd18: v = 17'd20252;
      7'd19: v = 17'd21336;
      7'd20: v = 17'd22415;
      7'd21: v = 17'd23486;
      7'd22: v = 17'd24550;
      7'd23: v = 17'd25607;
      7'd24: v = 17'd26656;
      7'd25: v = 17'd27697;
      7'd26: v = 17'd28729;
      7'd27: v = 17'd29753;
      7'd28: v = 17'd30767;
      7'd29: v = 17'd31772;
      7'd30: v = 17'd32768;
      7'd31: v = 17'd33754;
      7'd32: v = 17'd34729;
      7'd33: v = 17'd35693;
      7'd34: v = 17'd36647;
      7'd35: v = 17'd37590;
      7'd36: v = 17'd38521;
      7'd37: v = 17'd39441;
      7'd38: v = 17'd40348;
      7'd39: v = 17'd41243;
      7'd40: v = 17'd42126;
      7'd41: v = 17'd42995;
      7'd42: v = 17'd43852;
      7'd43: v = 17'd44695;
      7'd44: v = 17'd45525;
      7'd45: v = 17'd46341;
      7'd46: v = 17'd47143;
      7'd47: v = 17'd47930;
      7'd48: v = 17'd48703;
      7'd49: v = 17'd49461;
      7'd50: v = 17'd50203;
      7'd51: v = 17'd50931;
      7'd52: v = 17'd51643;
      7'd53: v = 17'd52339;
      7'd54: v = 17'd53020;
      7'd55: v = 17'd53684;
      7'd56: v = 17'd54332;
      7'd57: v = 17'd54963;
      7'd58: v = 17'd55578;
      7'd59: v = 17'd56175;
      7'd60: v = 17'd56756;
      7'd61: v = 17'd57319;
      7'd62: v = 17'd57865;
      7'd63: v = 17'd58393;
      7'd64: v = 17'd58903;
      7'd65: v = 17'd59396;
      7'd66: v = 17'd59870;
      7'd67: v = 17'd60326;
      7'd68: v = 17'd60764;
      7'd69: v = 17'd61183;
      7'd70: v = 17'd61584;
      7'd71: v = 17'd61966;
      7'd72: v = 17'd62328;
      7'd73: v = 17'd62672;
      7'd74: v = 17'd62997;
      7'd75: v = 17'd63303;
      7'd76: v = 17'd63589;
      7'd77: v = 17'd63856;
      7'd78: v = 17'd64104;
      7'd79: v = 17'd64332;
      7'd80: v = 17'd64540;
      7'd81: v = 17'd64729;
      7'd82: v = 17'd64898;
      7'd83: v = 17'd65048;
      7'd84: v = 17'd65177;
      7'd85: v = 17'd65287;
      7'd86: v = 17'd65376;
      7'd87: v = 17'd65446;
      7'd88: v = 17'd65496;
      7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Reduce an angle to 0..359 and fold by quadrant into cos / sin
  function automatic trig_t angle_trig(input logic signed [ANGLE_W-1:0] ang);
    logic signed [ANGLE_W:0] m1;
    logic signed [ANGLE_W:0] m2;
    logic [8:0]              m;
    logic [1:0]              quad;
    logic [8:0]              base;
    logic [6:0]              r;
    logic [6:0]              rc;
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] sc;
    trig_t                   t;
    m1 = (ang < 0) ? (ANGLE_W+1)'(ang) + 11'sd360 : (ANGLE_W+1)'(ang);
    m2 = (m1 < 0) ? m1 + 11'sd360 : m1;
    m  = (m2 >= 11'sd360) ? 9'(m2 - 11'sd360) : 9'(m2);
    if (m >= 9'd270) begin
      quad = 2'd3;
      base = 9'd270;
    end else if (m >= 9'd180) begin
      quad = 2'd2;
      base = 9'd180;
    end else if (m >= 9'd90) begin
      quad = 2'd1;
      base = 9'd90;
    end else begin
      quad = 2'd0;
      base = 9'd0;
    end
    r  = 7'(m - base);
    rc = 7'd90 - r;
    sr = signed'({1'b0, sin_rom(r)});
    sc = signed'({1'b0, sin_rom(rc)});
    case (quad)
      2'd0: begin
        t.sin_v = sr;
        t.cos_v = sc;
      end
      2'd1: begin
        t.sin_v = sc;
        t.cos_v = -sr;
      end
      2'd2: begin
        t.sin_v = -sr;
        t.cos_v = -sc;
      end
      default: begin
        t.sin_v = -sc;
        t.cos_v = sr;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rotation_source_address_generator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path: input register, then the single rotate/compare stage into the result register.
// Throughput: one request per cycle unless the output stalls; input register
//   and result register each hold one request.
// Reset: asynchronous active low; pipeline empties, angle 0, width and
//   height 1024.
module rotation_source_address_generator_core import rsag_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_res_o
);

  cfg_t cfg;

  // Register block
  rsag_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Address pipeline
  rsag_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule

`default_nettype wire

// ===== hdl/rsag_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers; angle is folded into cos / sin at write time
module rsag_cfg import rsag_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i,
  output cfg_t                      cfg_o
);

  localparam logic [DIM_W-1:0] MaxDimV = DIM_W'(MAX_DIM);

  cfg_t  cfg_q, cfg_d;
  trig_t trig;
  logic [DIM_W-1:0] dim_sat;

  // Trig lookup and size saturation on the write data
  assign trig    = angle_trig(signed'(cfg_wdata_i[ANGLE_W-1:0]));
  assign dim_sat = (cfg_wdata_i > MaxDimV) ? MaxDimV : cfg_wdata_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE: begin
          cfg_d.cos_v = trig.cos_v;
          cfg_d.sin_v = trig.sin_v;
        end
        CFG_WIDTH:  cfg_d.width  = dim_sat;
        CFG_HEIGHT: cfg_d.height = dim_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_v  <= TRIG_W'(signed'(1 <<< FRAC_BITS));
      cfg_q.sin_v  <= '0;
      cfg_q.width  <= DIM_RESET;
      cfg_q.height <= DIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // cos and sin are never zero together
  a_trig_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_q.cos_v == '0 && cfg_q.sin_v == '0))
    else $error("cos and sin both zero");

  // sizes stay saturated
  a_dim_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.width <= MaxDimV && cfg_q.height <= MaxDimV)
    else $error("image size above limit");

endmodule

`default_nettype wire

// ===== hdl/rsag_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-register pipeline: input register, rotate + range check, result register
module rsag_map import rsag_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_res_o
);

  localparam int PROD_W = TRIG_W + DIM_W;
  localparam int SUM_W  = 32;
  localparam int INT_W  = SUM_W - FRAC_BITS;

  logic s1_valid_q, s1_valid_d;
  in_t  s1_req_q;
  logic o_valid_q, o_valid_d;
  out_t o_res_q, o_res_d;
  logic adv;
  logic take;

  logic [COORD_W-1:0]       half_w, half_h;
  logic signed [DIM_W-1:0]  off_a, off_b;
  logic signed [PROD_W-1:0] p_ca, p_sb, p_sa, p_cb;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic [SUM_W-1:0]         mag_x, mag_y;
  logic [INT_W-1:0]         int_x, int_y;
  logic                     ok_x, ok_y, ok;

  // Handshake: result register frees up or is empty
  assign adv        = !o_valid_q || !out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !adv;
  assign s1_valid_d = take ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign o_valid_d  = adv ? s1_valid_q : o_valid_q;

  // Offsets from the image center
  assign half_w = cfg_i.width[DIM_W-1:1];
  assign half_h = cfg_i.height[DIM_W-1:1];
  assign off_a  = signed'({1'b0, s1_req_q.dest_x}) - signed'({1'b0, half_w});
  assign off_b  = signed'({1'b0, s1_req_q.dest_y}) - signed'({1'b0, half_h});

  // Rotation products
  assign p_ca = PROD_W'(cfg_i.cos_v) * PROD_W'(off_a);
  assign p_sb = PROD_W'(cfg_i.sin_v) * PROD_W'(off_b);
  assign p_sa = PROD_W'(cfg_i.sin_v) * PROD_W'(off_a);
  assign p_cb = PROD_W'(cfg_i.cos_v) * PROD_W'(off_b);

  assign sum_x = SUM_W'(p_ca) + SUM_W'(p_sb)
               + signed'({{(SUM_W-COORD_W-FRAC_BITS){1'b0}}, half_w, {FRAC_BITS{1'b0}}});
  assign sum_y = SUM_W'(p_cb) - SUM_W'(p_sa)
               + signed'({{(SUM_W-COORD_W-FRAC_BITS){1'b0}}, half_h, {FRAC_BITS{1'b0}}});

  // Truncate toward zero, then range check
  assign mag_x = sum_x[SUM_W-1] ? unsigned'(-sum_x) : unsigned'(sum_x);
  assign mag_y = sum_y[SUM_W-1] ? unsigned'(-sum_y) : unsigned'(sum_y);
  assign int_x = mag_x[SUM_W-1:FRAC_BITS];
  assign int_y = mag_y[SUM_W-1:FRAC_BITS];
  assign ok_x  = (!sum_x[SUM_W-1] || int_x == '0) && (int_x < INT_W'(cfg_i.width));
  assign ok_y  = (!sum_y[SUM_W-1] || int_y == '0) && (int_y < INT_W'(cfg_i.height));
  assign ok    = ok_x && ok_y;

  always_comb begin
    o_res_d = o_res_q;
    if (adv) begin
      o_res_d.out_dest_x = s1_req_q.dest_x;
      o_res_d.out_dest_y = s1_req_q.dest_y;
      o_res_d.src_x      = ok ? int_x[COORD_W-1:0] : '0;
      o_res_d.src_y      = ok ? int_y[COORD_W-1:0] : '0;
      o_res_d.in_range   = ok;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_req_q <= in_req_i;
    end
    o_res_q <= o_res_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = o_res_q;

  // an item in the input register moves on when the result register frees
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && adv |=> o_valid_q)
    else $error("request lost between stages");

  // out-of-range results carry a zero source address
  a_zero_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !o_res_q.in_range |-> o_res_q.src_x == '0 && o_res_q.src_y == '0)
    else $error("nonzero source for out-of-range pixel");

endmodule

`default_nettype wire
